### rtl/core/nat_port_translation_table_core_macros.svh
// Assertion macros for the port translation table core.
`ifndef NAT_PORT_TRANSLATION_TABLE_CORE_MACROS_SVH
`define NAT_PORT_TRANSLATION_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define NPT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define NPT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define NPT_ASSERT_IMP(label, clk, rst_n, a, c)
`define NPT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/core/npt_pkg.sv
package npt_pkg;
    localparam int unsigned Entries = 16;
    localparam int unsigned IdxW = $clog2(Entries);
    localparam int unsigned CntW = 5;
    localparam int unsigned QDepth = 2;

    localparam logic [1:0] CMD_OUT = 2'd0;
    localparam logic [1:0] CMD_IN = 2'd1;
    localparam logic [1:0] CMD_EXP = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NOMAP = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // configuration register indexes
    localparam logic [0:0] REG_PUBLIC_ADDR = 1'd0;
    localparam logic [0:0] REG_FIRST_PORT = 1'd1;

    typedef enum logic [1:0] {
        OP_OUT = 2'd0,
        OP_IN = 2'd1,
        OP_EXP = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [31:0] now_time;
        logic [31:0] idle_time;
        logic [7:0] proto;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_proto;
        logic [31:0] out_src_addr;
        logic [15:0] out_src_port;
        logic [31:0] out_dst_addr;
        logic [15:0] out_dst_port;
        logic [CntW-1:0] expired_count;
    } rsp_t;

    // classified work item between front and back
    typedef struct packed {
        op_t op;
        logic [1:0] reject_status;
        req_t req;
    } work_t;
endpackage

### rtl/core/npt_stream_if.sv
interface npt_stream_if #(parameter type payload_t = logic) ();
    logic valid;
    logic ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/npt_front.sv
module npt_front (
    npt_stream_if.sink req,
    input  logic [31:0] public_addr,
    output logic q_push,
    output npt_pkg::work_t q_data,
    input  logic q_full
);
    logic tuple_ok;

    assign req.ready = !q_full;
    assign q_push = req.valid && !q_full;

    assign tuple_ok = (req.payload.proto == npt_pkg::PROTO_TCP
                       || req.payload.proto == npt_pkg::PROTO_UDP)
                      && req.payload.src_port != 16'd0 && req.payload.dst_port != 16'd0;

    always_comb
    begin
        q_data.req = req.payload;
        q_data.op = npt_pkg::OP_REJECT;
        q_data.reject_status = npt_pkg::ST_MALFORMED;
        case (req.payload.cmd)
            npt_pkg::CMD_EXP: q_data.op = npt_pkg::OP_EXP;
            npt_pkg::CMD_OUT:
            begin
                if (tuple_ok)
                    q_data.op = npt_pkg::OP_OUT;
            end
            npt_pkg::CMD_IN:
            begin
                if (tuple_ok && req.payload.dst_addr == public_addr)
                    q_data.op = npt_pkg::OP_IN;
                else if (tuple_ok)
                    q_data.reject_status = npt_pkg::ST_NOMAP;
            end
            default: q_data.op = npt_pkg::OP_REJECT;
        endcase
    end
endmodule

### rtl/core/npt_queue.sv
`include "nat_port_translation_table_core_macros.svh"
module npt_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  npt_pkg::work_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output npt_pkg::work_t head
);
    localparam int unsigned PtrW = $clog2(npt_pkg::QDepth);
    npt_pkg::work_t mem_reg [npt_pkg::QDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0] cnt_reg;

    assign full = cnt_reg == (PtrW+1)'(npt_pkg::QDepth);
    assign not_empty = cnt_reg != '0;
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `NPT_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
    `NPT_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, not_empty)
    `NPT_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= (PtrW+1)'(npt_pkg::QDepth))
endmodule

### rtl/core/npt_back.sv
`include "nat_port_translation_table_core_macros.svh"
module npt_back (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  npt_pkg::work_t q_head,
    output logic q_pop,
    input  logic [31:0] public_addr,
    input  logic [15:0] first_public_port,
    npt_stream_if.source rsp
);
    localparam int unsigned IdxW = npt_pkg::IdxW;
    localparam int unsigned Entries = npt_pkg::Entries;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_PORT = 6'b000100,
        S_EXP = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [Entries-1:0] valid_reg;
    logic [7:0] e_proto [Entries];
    logic [31:0] e_paddr [Entries];
    logic [15:0] e_pport [Entries];
    logic [31:0] e_raddr [Entries];
    logic [15:0] e_rport [Entries];
    logic [15:0] e_pub [Entries];
    logic [31:0] e_last [Entries];

    npt_pkg::work_t w_reg;
    logic [IdxW:0] idx_reg;
    logic hit_reg, slot_ok_reg;
    logic [IdxW-1:0] hit_idx_reg, slot_reg;
    logic [16:0] cand_reg;
    logic [15:0] port_reg;
    logic [4:0] cnt_reg;
    logic out_valid_reg;
    npt_pkg::rsp_t out_reg, out_next;
    logic out_load;

    logic [IdxW-1:0] ix;
    logic out_match, in_match, port_used, exp_hit;
    logic [31:0] age;

    assign ix = idx_reg[IdxW-1:0];
    // a new transaction starts only once the previous result has been taken
    assign q_pop = state_reg == S_IDLE && q_valid && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    // serial walk: one entry per cycle
    assign out_match = valid_reg[ix] && e_proto[ix] == w_reg.req.proto
        && e_pport[ix] == w_reg.req.src_port && e_rport[ix] == w_reg.req.dst_port
        && e_paddr[ix] == w_reg.req.src_addr && e_raddr[ix] == w_reg.req.dst_addr;
    assign in_match = valid_reg[ix] && e_proto[ix] == w_reg.req.proto
        && e_pub[ix] == w_reg.req.dst_port && e_rport[ix] == w_reg.req.src_port
        && e_raddr[ix] == w_reg.req.src_addr;
    assign port_used = valid_reg[ix] && e_pub[ix] == cand_reg[15:0];
    assign age = w_reg.req.now_time - e_last[ix];
    assign exp_hit = valid_reg[ix] && w_reg.req.now_time >= e_last[ix]
        && age >= w_reg.req.idle_time;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_head.op)
                        npt_pkg::OP_OUT, npt_pkg::OP_IN: state_next = S_SCAN;
                        npt_pkg::OP_EXP: state_next = S_EXP;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg == (IdxW+1)'(Entries - 1)
                    || (w_reg.op == npt_pkg::OP_OUT ? out_match : in_match))
                begin
                    if (w_reg.op == npt_pkg::OP_OUT && !out_match)
                        state_next = S_PORT;
                    else
                        state_next = S_WRITE;
                end
            end
            S_PORT:
            begin
                if (cand_reg[16] || !slot_ok_reg)
                    state_next = S_WRITE;
                else if (idx_reg == (IdxW+1)'(Entries - 1) && !port_used)
                    state_next = S_WRITE;
            end
            S_EXP:
            begin
                if (idx_reg == (IdxW+1)'(Entries - 1))
                    state_next = S_OUT;
            end
            S_WRITE: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // result word for the transaction in hand
    always_comb
    begin
        out_next = '0;
        out_load = 1'b0;
        if (state_reg == S_WRITE)
        begin
            out_load = 1'b1;
            if (w_reg.op == npt_pkg::OP_OUT)
            begin
                if (!hit_reg && (!slot_ok_reg || cand_reg[16]))
                    out_next.status = npt_pkg::ST_FULL;
                else
                begin
                    out_next.status = npt_pkg::ST_OK;
                    out_next.out_proto = w_reg.req.proto;
                    out_next.out_src_addr = public_addr;
                    out_next.out_src_port = hit_reg ? e_pub[hit_idx_reg] : cand_reg[15:0];
                    out_next.out_dst_addr = w_reg.req.dst_addr;
                    out_next.out_dst_port = w_reg.req.dst_port;
                end
            end
            else if (!hit_reg)
                out_next.status = npt_pkg::ST_NOMAP;
            else
            begin
                out_next.status = npt_pkg::ST_OK;
                out_next.out_proto = w_reg.req.proto;
                out_next.out_src_addr = w_reg.req.src_addr;
                out_next.out_src_port = w_reg.req.src_port;
                out_next.out_dst_addr = e_paddr[hit_idx_reg];
                out_next.out_dst_port = e_pport[hit_idx_reg];
            end
        end
        else if (state_reg == S_EXP && state_next == S_OUT)
        begin
            out_load = 1'b1;
            out_next.status = npt_pkg::ST_OK;
            out_next.expired_count = (exp_hit && cnt_reg != 5'd31) ? cnt_reg + 5'd1
                                                                    : cnt_reg;
        end
        else if (q_pop && q_head.op == npt_pkg::OP_REJECT)
        begin
            out_load = 1'b1;
            out_next.status = q_head.reject_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            slot_ok_reg <= 1'b0;
            cnt_reg <= '0;
            cand_reg <= '0;
            slot_reg <= '0;
            hit_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    hit_reg <= 1'b0;
                    slot_ok_reg <= 1'b0;
                    cnt_reg <= '0;
                    // zero first port behaves as one
                    cand_reg <= (first_public_port == 16'd0) ? 17'd1
                                                             : {1'b0, first_public_port};
                end
                S_SCAN:
                begin
                    if (!valid_reg[ix] && !slot_ok_reg)
                    begin
                        slot_ok_reg <= 1'b1;
                        slot_reg <= ix;
                    end
                    if (w_reg.op == npt_pkg::OP_OUT ? out_match : in_match)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= ix;
                    end
                    if (state_next == S_SCAN)
                        idx_reg <= idx_reg + 1'b1;
                    else
                        idx_reg <= '0;
                end
                S_PORT:
                begin
                    // restart the entry walk on every used candidate
                    if (port_used)
                    begin
                        cand_reg <= cand_reg + 1'b1;
                        idx_reg <= '0;
                    end
                    else if (idx_reg != (IdxW+1)'(Entries - 1))
                        idx_reg <= idx_reg + 1'b1;
                end
                S_EXP:
                begin
                    if (exp_hit)
                    begin
                        valid_reg[ix] <= 1'b0;
                        if (cnt_reg != 5'd31)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_WRITE:
                begin
                    if (w_reg.op == npt_pkg::OP_OUT && !hit_reg && slot_ok_reg
                        && !cand_reg[16])
                        valid_reg[slot_reg] <= 1'b1;
                end
                S_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            w_reg <= q_head;
        if (state_reg == S_WRITE)
        begin
            if (w_reg.op == npt_pkg::OP_OUT && !hit_reg && slot_ok_reg && !cand_reg[16])
            begin
                e_proto[slot_reg] <= w_reg.req.proto;
                e_paddr[slot_reg] <= w_reg.req.src_addr;
                e_pport[slot_reg] <= w_reg.req.src_port;
                e_raddr[slot_reg] <= w_reg.req.dst_addr;
                e_rport[slot_reg] <= w_reg.req.dst_port;
                e_pub[slot_reg] <= cand_reg[15:0];
                e_last[slot_reg] <= w_reg.req.now_time;
            end
            else if (hit_reg)
                e_last[hit_idx_reg] <= w_reg.req.now_time;
        end
        if (out_load)
            out_reg <= out_next;
    end

    `NPT_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `NPT_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_reg == S_IDLE)
    `NPT_ASSERT_NXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready,
                    rsp.valid && $stable(rsp.payload))
endmodule

### rtl/core/nat_port_translation_table_core.sv
// Sequence: a reject needs no table walk; a lookup walks the entries up to a hit, all
// of them on a miss; an outbound miss then walks them again for a free public port,
// restarting on each candidate in use, unless no entry is free; expire walks them all.
// Throughput: one transaction at a time in the back end, set by the serial entry walk;
// the next one starts only once the previous result has been taken.
// Reset: rst_n asynchronous active low; table empty, public_addr 0, first port 1024.
module nat_port_translation_table_core (
    input  logic clk,
    input  logic rst_n,
    npt_stream_if.sink req,
    npt_stream_if.source rsp,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [31:0] cfg_wdata
);
    logic [31:0] public_addr_reg;
    logic [15:0] port_base_reg;
    logic q_push, q_full, q_pop, q_valid;
    npt_pkg::work_t q_in, q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            public_addr_reg <= '0;
            port_base_reg <= 16'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                npt_pkg::REG_PUBLIC_ADDR: public_addr_reg <= cfg_wdata;
                npt_pkg::REG_FIRST_PORT: port_base_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // front: classify, and reject malformed transactions and inbound ones not for the public address
    npt_front u_front (
        .req(req), .public_addr(public_addr_reg),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    npt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .head(q_head)
    );

    // back: table walk, port allocation, expiry, result register
    npt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .public_addr(public_addr_reg), .first_public_port(port_base_reg), .rsp(rsp)
    );
endmodule

### tb/nat_port_translation_table_core_test.sv
`timescale 1ns / 1ps

module nat_port_translation_table_core_test;
    localparam int unsigned Entries = npt_pkg::Entries;
    localparam int unsigned CycleLimit = 1500000;
    localparam int unsigned DrainCycles = 400;
    localparam int unsigned FlowPool = 24;
    localparam int unsigned Segments = 6;
    localparam int unsigned SegItems = 242;

    // Mirror of the translation table plus the queue of pending answers.
    class npt_scoreboard;
        logic [31:0] nat_addr;
        logic [15:0] port_base;
        bit          slot_valid [Entries];
        logic [7:0]  slot_proto [Entries];
        logic [31:0] slot_priv_addr [Entries];
        logic [15:0] slot_priv_port [Entries];
        logic [31:0] slot_rem_addr [Entries];
        logic [15:0] slot_rem_port [Entries];
        logic [15:0] slot_pub_port [Entries];
        logic [31:0] slot_last_used [Entries];
        npt_pkg::rsp_t pending_rsp [$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned hits;
        int unsigned fulls;
        int unsigned freed;

        function new();
            nat_addr = '0;
            port_base = 16'd1024;
            mismatches = 0;
            checked = 0;
            hits = 0;
            fulls = 0;
            freed = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        function void set_config(logic [31:0] addr, logic [15:0] port);
            nat_addr = addr;
            port_base = port;
        endfunction

        function bit port_in_use(int unsigned port);
            foreach (slot_valid[i])
                if (slot_valid[i] && slot_pub_port[i] == port[15:0])
                    return 1'b1;
            return 1'b0;
        endfunction

        // Works out the answer to one accepted transaction and updates the mirror.
        function void note_request(npt_pkg::req_t r);
            npt_pkg::rsp_t e;
            int hit;
            int slot;
            int unsigned cand;
            int unsigned cnt;
            bit found;
            e = '0;
            hit = -1;
            slot = -1;
            cnt = 0;
            found = 1'b0;
            if (r.cmd == npt_pkg::CMD_EXP) begin
                foreach (slot_valid[i])
                    if (slot_valid[i] && r.now_time >= slot_last_used[i]
                        && (r.now_time - slot_last_used[i]) >= r.idle_time) begin
                        slot_valid[i] = 1'b0;
                        if (cnt < 31) cnt++;
                    end
                freed += cnt;
                e.status = npt_pkg::ST_OK;
                e.expired_count = cnt[4:0];
            end else if (r.cmd == npt_pkg::OP_REJECT
                         || !((r.proto == npt_pkg::PROTO_TCP || r.proto == npt_pkg::PROTO_UDP)
                              && r.src_port != 16'd0 && r.dst_port != 16'd0)) begin
                e.status = npt_pkg::ST_MALFORMED;
            end else if (r.cmd == npt_pkg::CMD_OUT) begin
                for (int i = 0; i < Entries; i++) begin
                    if (slot_valid[i] && slot_proto[i] == r.proto
                        && slot_priv_port[i] == r.src_port && slot_rem_port[i] == r.dst_port
                        && slot_priv_addr[i] == r.src_addr && slot_rem_addr[i] == r.dst_addr) begin
                        hit = i;
                        break;
                    end
                    if (slot < 0 && !slot_valid[i]) slot = i;
                end
                if (hit >= 0) begin
                    cand = 32'(slot_pub_port[hit]);
                    slot_last_used[hit] = r.now_time;
                    hits++;
                end else begin
                    if (slot >= 0) begin
                        // zero first port behaves as one
                        for (cand = (port_base == 16'd0) ? 32'd1 : 32'(port_base);
                             cand <= 32'd65535; cand++)
                            if (!port_in_use(cand)) begin
                                found = 1'b1;
                                break;
                            end
                    end
                    if (!found) begin
                        e.status = npt_pkg::ST_FULL;
                        fulls++;
                        pending_rsp.push_back(e);
                        return;
                    end
                    slot_valid[slot] = 1'b1;
                    slot_proto[slot] = r.proto;
                    slot_priv_addr[slot] = r.src_addr;
                    slot_priv_port[slot] = r.src_port;
                    slot_rem_addr[slot] = r.dst_addr;
                    slot_rem_port[slot] = r.dst_port;
                    slot_pub_port[slot] = cand[15:0];
                    slot_last_used[slot] = r.now_time;
                end
                e.status = npt_pkg::ST_OK;
                e.out_proto = r.proto;
                e.out_src_addr = nat_addr;
                e.out_src_port = cand[15:0];
                e.out_dst_addr = r.dst_addr;
                e.out_dst_port = r.dst_port;
            end else begin
                if (r.dst_addr == nat_addr)
                    for (int i = 0; i < Entries; i++)
                        if (slot_valid[i] && slot_proto[i] == r.proto
                            && slot_pub_port[i] == r.dst_port && slot_rem_port[i] == r.src_port
                            && slot_rem_addr[i] == r.src_addr) begin
                            hit = i;
                            break;
                        end
                if (hit < 0) begin
                    e.status = npt_pkg::ST_NOMAP;
                end else begin
                    slot_last_used[hit] = r.now_time;
                    hits++;
                    e.status = npt_pkg::ST_OK;
                    e.out_proto = r.proto;
                    e.out_src_addr = r.src_addr;
                    e.out_src_port = r.src_port;
                    e.out_dst_addr = slot_priv_addr[hit];
                    e.out_dst_port = slot_priv_port[hit];
                end
            end
            pending_rsp.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        endtask

        task check_response(npt_pkg::rsp_t got);
            npt_pkg::rsp_t w;
            if (pending_rsp.size() == 0) begin
                report("unexpected transaction, status", 32'(got.status), 32'd0);
                return;
            end
            w = pending_rsp.pop_front();
            checked++;
            if (got.status != w.status)
                report("status", 32'(got.status), 32'(w.status));
            if (got.out_proto != w.out_proto)
                report("out_proto", 32'(got.out_proto), 32'(w.out_proto));
            if (got.out_src_addr != w.out_src_addr)
                report("out_src_addr", got.out_src_addr, w.out_src_addr);
            if (got.out_src_port != w.out_src_port)
                report("out_src_port", 32'(got.out_src_port), 32'(w.out_src_port));
            if (got.out_dst_addr != w.out_dst_addr)
                report("out_dst_addr", got.out_dst_addr, w.out_dst_addr);
            if (got.out_dst_port != w.out_dst_port)
                report("out_dst_port", 32'(got.out_dst_port), 32'(w.out_dst_port));
            if (got.expired_count != w.expired_count)
                report("expired_count", 32'(got.expired_count), 32'(w.expired_count));
        endtask
    endclass

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] priv_addr;
        logic [15:0] priv_port;
        logic [31:0] rem_addr;
        logic [15:0] rem_port;
    } flow_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [31:0] cfg_wdata;

    npt_stream_if #(.payload_t(npt_pkg::req_t)) req_ch ();
    npt_stream_if #(.payload_t(npt_pkg::rsp_t)) rsp_ch ();

    nat_port_translation_table_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    npt_scoreboard sb = new();

    flow_t       flows [FlowPool];
    logic [31:0] tick;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned hold_off;
    int unsigned cycles;
    int unsigned sent;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off = 0;
        cycles = 0;
        sent = 0;
        tick = 32'd100;
    end

    // Watchdog: a correct run finishes far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL nat_port_translation_table_core");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor; values sampled here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.payload);
    end

    // Offers one transaction and returns on the edge where it is taken.
    // ready only moves at rising edges, so its level at the falling edge holds
    // at the next rising one.
    task send_request(npt_pkg::req_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(negedge clk);
        while (!req_ch.ready) @(negedge clk);
        @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    task send_fields(logic [1:0] cmd, logic [31:0] now, logic [31:0] idle, logic [7:0] proto,
                     logic [31:0] sa, logic [15:0] sp, logic [31:0] da, logic [15:0] dp);
        npt_pkg::req_t r;
        r.cmd = cmd;
        r.now_time = now;
        r.idle_time = idle;
        r.proto = proto;
        r.src_addr = sa;
        r.src_port = sp;
        r.dst_addr = da;
        r.dst_port = dp;
        send_request(r);
    endtask

    // Only touched once the block has answered everything it was given.
    task write_config(logic [31:0] addr, logic [15:0] port);
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= npt_pkg::REG_PUBLIC_ADDR;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_index <= npt_pkg::REG_FIRST_PORT;
        cfg_wdata <= {16'd0, port};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(addr, port);
        @(posedge clk);
    endtask

    function logic [15:0] pick_port();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return 16'hFFFF;
        if (k == 1) return 16'd1;
        return 16'($urandom_range(65535, 1));
    endfunction

    function flow_t fresh_flow();
        flow_t f;
        f.proto = $urandom_range(1) ? npt_pkg::PROTO_TCP : npt_pkg::PROTO_UDP;
        f.priv_addr = $urandom();
        f.priv_port = pick_port();
        f.rem_addr = $urandom();
        f.rem_port = pick_port();
        return f;
    endfunction

    // One random transaction, mostly well-formed flows with some noise mixed in.
    task random_request();
        npt_pkg::req_t r;
        flow_t f;
        int unsigned k;
        int unsigned s;
        tick = tick + $urandom_range(20);
        r = '0;
        r.now_time = tick;
        r.idle_time = $urandom();
        k = $urandom_range(99);
        if (k < 40) begin
            s = $urandom_range(FlowPool - 1);
            if ($urandom_range(15) == 0) flows[s] = fresh_flow();
            f = flows[s];
            r.cmd = npt_pkg::CMD_OUT;
            r.proto = f.proto;
            r.src_addr = f.priv_addr;
            r.src_port = f.priv_port;
            r.dst_addr = f.rem_addr;
            r.dst_port = f.rem_port;
        end else if (k < 72) begin
            // reply traffic aimed at a live mapping when the picked slot holds one, sometimes slightly off
            s = $urandom_range(Entries - 1);
            r.cmd = npt_pkg::CMD_IN;
            r.dst_addr = sb.nat_addr;
            if (sb.slot_valid[s]) begin
                r.proto = sb.slot_proto[s];
                r.src_addr = sb.slot_rem_addr[s];
                r.src_port = sb.slot_rem_port[s];
                r.dst_port = sb.slot_pub_port[s];
            end else begin
                r.proto = npt_pkg::PROTO_UDP;
                r.src_addr = $urandom();
                r.src_port = pick_port();
                r.dst_port = pick_port();
            end
            case ($urandom_range(9))
                0: r.dst_addr = r.dst_addr ^ (32'd1 << $urandom_range(31));
                1: r.dst_port = r.dst_port + 16'd1;
                2: r.src_addr = $urandom();
                3: r.proto = (r.proto == npt_pkg::PROTO_TCP) ? npt_pkg::PROTO_UDP
                                                             : npt_pkg::PROTO_TCP;
                default: ;
            endcase
        end else if (k < 82) begin
            r.cmd = npt_pkg::CMD_EXP;
            case ($urandom_range(5))
                0: r.idle_time = 32'd0;
                1: r.now_time = $urandom_range(50);
                2: r.now_time = 32'hFFFF_FFFF;
                default: r.idle_time = $urandom_range(400);
            endcase
        end else begin
            r.cmd = 2'($urandom_range(3));
            r.now_time = $urandom();
            r.idle_time = $urandom();
            r.proto = $urandom_range(1) ? 8'($urandom()) : npt_pkg::PROTO_TCP;
            r.src_addr = $urandom();
            r.src_port = 16'($urandom());
            r.dst_addr = $urandom_range(1) ? $urandom() : sb.nat_addr;
            r.dst_port = 16'($urandom());
        end
        send_request(r);
    endtask

    initial
    begin
        int unsigned seg;
        foreach (flows[i]) flows[i] = fresh_flow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (public address 0, first port 1024).
        send_fields(npt_pkg::CMD_OUT, 32'd10, 32'd0, npt_pkg::PROTO_TCP, 32'h0A00_0001, 16'd1,
                    32'hFFFF_FFFF, 16'hFFFF);
        send_fields(npt_pkg::CMD_OUT, 32'd11, 32'd0, npt_pkg::PROTO_UDP, 32'hFFFF_FFFF,
                    16'hFFFF, 32'h0, 16'd1);
        send_fields(npt_pkg::CMD_OUT, 32'd12, 32'd0, npt_pkg::PROTO_TCP, 32'h0A00_0001, 16'd1,
                    32'hFFFF_FFFF, 16'hFFFF);
        send_fields(npt_pkg::CMD_OUT, 32'd13, 32'd0, 8'd0, 32'h1, 16'd5, 32'h2, 16'd6);
        send_fields(npt_pkg::CMD_OUT, 32'd13, 32'd0, 8'hFF, 32'h1, 16'd5, 32'h2, 16'd6);
        send_fields(npt_pkg::CMD_OUT, 32'd13, 32'd0, npt_pkg::PROTO_TCP, 32'h1, 16'd0,
                    32'h2, 16'd6);
        send_fields(npt_pkg::CMD_IN, 32'd13, 32'd0, npt_pkg::PROTO_TCP, 32'h1, 16'd5,
                    32'h0, 16'd0);
        send_fields(npt_pkg::OP_REJECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, npt_pkg::PROTO_TCP,
                    32'h1, 16'd5, 32'h0, 16'd1024);
        send_fields(npt_pkg::CMD_IN, 32'd20, 32'd0, npt_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                    16'hFFFF, 32'h0, 16'd1024);
        send_fields(npt_pkg::CMD_IN, 32'd21, 32'd0, npt_pkg::PROTO_UDP, 32'h0, 16'd1,
                    32'h0, 16'd1025);
        send_fields(npt_pkg::CMD_IN, 32'd22, 32'd0, npt_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                    16'hFFFF, 32'h5, 16'd1024);
        send_fields(npt_pkg::CMD_IN, 32'd22, 32'd0, npt_pkg::PROTO_UDP, 32'h0, 16'd1,
                    32'h0, 16'd1024);
        // clock behind: nothing may be freed
        send_fields(npt_pkg::CMD_EXP, 32'd5, 32'd0, 8'd0, 32'd0, 16'd0, 32'd0, 16'd0);
        send_fields(npt_pkg::CMD_EXP, 32'd30, 32'd9, 8'd0, 32'd0, 16'd0, 32'd0, 16'd0);
        send_fields(npt_pkg::CMD_EXP, 32'd30, 32'hFFFF_FFFF, 8'd0, 32'd0, 16'd0, 32'd0, 16'd0);
        // zero idle limit frees everything that is not in the future
        send_fields(npt_pkg::CMD_EXP, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0, 16'd0, 32'd0, 16'd0);
        send_fields(npt_pkg::CMD_IN, 32'd40, 32'd0, npt_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                    16'hFFFF, 32'h0, 16'd1024);

        // Random segments, each under its own settings; segments share idling patterns in pairs.
        for (seg = 0; seg < Segments; seg++) begin
            case (seg)
                0: write_config(32'hC0A8_0001, 16'd1024);
                1: write_config(32'hFFFF_FFFF, 16'hFFFF);
                2: write_config(32'h0, 16'd0);
                3: write_config($urandom(), 16'd65530);
                4: write_config($urandom(), 16'd1);
                default: write_config(32'h0A00_0001, 16'd40000);
            endcase
            tx_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 46 : 0;
            rx_idle_pct = (seg < 2) ? 46 : (seg < 4) ? 17 : 0;
            // long receiver stall so the block backs up into its input
            if (seg == 4) hold_off = 600;
            repeat (SegItems) random_request();
        end
        req_ch.valid <= 1'b0;

        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d transactions, %0d checked: %0d mapping hits, %0d full answers,",
                 sent, sb.checked, sb.hits, sb.fulls);
        $display("%0d entries aged out over six settings of address and first port", sb.freed);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
            $display("PASS nat_port_translation_table_core");
        end else begin
            $display("FAIL nat_port_translation_table_core");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/npt_pkg.sv
rtl/core/npt_stream_if.sv
rtl/core/npt_front.sv
rtl/core/npt_queue.sv
rtl/core/npt_back.sv
rtl/core/nat_port_translation_table_core.sv
tb/nat_port_translation_table_core_test.sv
